// ----- rtl/ttr_pkg.sv -----
// ----------------------------------------------------------------------------
// ttr_pkg
// Types and constants shared by the touch tap recognizer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package ttr_pkg;

   localparam int COORD_W     = 10;
   localparam int TIME_W      = 32;
   localparam int HOLD_W      = 16;
   localparam int CSR_ADDR_W  = 5;
   localparam int CSR_DATA_W  = 32;
   localparam int REQ_TDATA_W = 72;
   localparam int REQ_TUSER_W = 1;
   localparam int RSP_TDATA_W = 24;

   // portrait rotation base: x = ROT_BASE - raw_y
   localparam logic [COORD_W-1:0] ROT_BASE   = 10'd539;
   localparam int                 READY_BIT  = 7;
   localparam logic [3:0]         COUNT_MASK = 4'hF;

   // register indexes (byte address = 4 * index)
   localparam logic [2:0] REG_MAPPING_VERIFIED = 3'd0;
   localparam logic [2:0] REG_MAX_MOVE         = 3'd1;
   localparam logic [2:0] REG_MIN_HOLD_MS      = 3'd2;
   localparam logic [2:0] REG_MAX_HOLD_MS      = 3'd3;
   localparam logic [2:0] REG_REFRACTORY_MS    = 3'd4;

   localparam logic [COORD_W-1:0] MAX_MOVE_RST      = 10'd24;
   localparam logic [HOLD_W-1:0]  MIN_HOLD_MS_RST   = 16'd35;
   localparam logic [HOLD_W-1:0]  MAX_HOLD_MS_RST   = 16'd1200;
   localparam logic [HOLD_W-1:0]  REFRACTORY_MS_RST = 16'd600;

   typedef struct packed {
      logic               mapping_verified;
      logic [COORD_W-1:0] max_move;
      logic [HOLD_W-1:0]  min_hold_ms;
      logic [HOLD_W-1:0]  max_hold_ms;
      logic [HOLD_W-1:0]  refractory_ms;
   } cfg_type;

   // last member sits in the lowest bits: {tuser, tdata}
   typedef struct packed {
      logic              read_ok;
      logic [TIME_W-1:0] now_ms;
      logic [15:0]       raw_y;
      logic [15:0]       raw_x;
      logic [7:0]        status;
   } req_item_type;

   typedef struct packed {
      logic               ack_status;
      logic [COORD_W-1:0] pos_y;
      logic [COORD_W-1:0] pos_x;
      logic               tap;
   } rsp_item_type;

   typedef struct packed {
      logic               touch_down;
      logic [COORD_W-1:0] start_x;
      logic [COORD_W-1:0] start_y;
      logic [COORD_W-1:0] last_x;
      logic [COORD_W-1:0] last_y;
      logic [TIME_W-1:0]  press_time;
      logic [TIME_W-1:0]  last_accept_time;
   } track_type;

endpackage

`default_nettype wire

// ----- rtl/touch_tap_recognizer_top.sv -----
// ----------------------------------------------------------------------------
// touch_tap_recognizer_top
// Turns touch-panel polls into press tracking and tap decisions.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one panel poll per transaction (read flag in tuser, status,
//   raw X/Y and a millisecond time in tdata). rsp_* returns exactly one result
//   per poll, in order: tap flag, canvas X/Y and the status-clear request.
//   csr_* is an APB port with the acceptance thresholds; write it only while
//   no poll is in flight.
//   A poll is held in the input register, then passes through the rotate/clamp
//   and tap decision logic feeding the result register, where the press
//   tracking state is updated too.
//   Throughput is one poll per cycle while rsp_tready is high; the 32-bit time
//   subtract and compare into the result register sets the cycle time.
//   Reset clears both pipeline valid flags and the press tracking state, and
//   loads the register defaults. When rsp_tready is low the result holds,
//   one more poll is taken into the input register, then req_tready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module touch_tap_recognizer_top #(
   parameter int CANVAS_WIDTH  = 540,
   parameter int CANVAS_HEIGHT = 960
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   // status[7:0], raw_x[23:8], raw_y[39:24], now_ms[71:40]
   input  wire logic [ttr_pkg::REQ_TDATA_W-1:0] req_tdata,
   // read_ok[0]
   input  wire logic [ttr_pkg::REQ_TUSER_W-1:0] req_tuser,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   // tap[0], pos_x[10:1], pos_y[20:11], ack_status[21], zeros[23:22]
   output logic      [ttr_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input  wire logic                            csr_psel,
   input  wire logic                            csr_penable,
   input  wire logic                            csr_pwrite,
   input  wire logic [ttr_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  wire logic [ttr_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic      [ttr_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                                 csr_pready
);
   import ttr_pkg::*;

   localparam logic [COORD_W-1:0] X_MAX = COORD_W'(CANVAS_WIDTH - 1);
   localparam logic [COORD_W-1:0] Y_MAX = COORD_W'(CANVAS_HEIGHT - 1);

   cfg_type      cfg;
   req_item_type s1_item_ff;
   logic         s1_valid_ff;
   logic         s1_valid_in;
   rsp_item_type rsp_item_ff;
   rsp_item_type rsp_item_in;
   logic         rsp_valid_ff;
   logic         rsp_valid_in;
   track_type    trk_ff;
   track_type    trk_in;

   logic               req_fire;
   logic               advance;
   logic               pressed;
   logic [COORD_W-1:0] rot_x;
   logic [COORD_W-1:0] px;
   logic [COORD_W-1:0] py;
   logic [COORD_W-1:0] dx;
   logic [COORD_W-1:0] dy;
   logic [TIME_W-1:0]  held;
   logic [TIME_W-1:0]  since_tap;
   logic               tap_ok;

   ttr_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // handshake
   assign advance    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_TDATA_W'(rsp_item_ff);

   assign s1_valid_in  = req_fire ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = advance ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   // rotate to portrait and clamp to the canvas
   assign pressed = s1_item_ff.status[READY_BIT] && ((s1_item_ff.status[3:0] & COUNT_MASK) != 4'd0);
   assign rot_x   = ROT_BASE - s1_item_ff.raw_y[COORD_W-1:0];
   assign px      = (s1_item_ff.raw_y > 16'(ROT_BASE)) ? '0 :
                    ((rot_x > X_MAX) ? X_MAX : rot_x);
   assign py      = (s1_item_ff.raw_x > 16'(Y_MAX)) ? Y_MAX : s1_item_ff.raw_x[COORD_W-1:0];

   assign dx = (trk_ff.last_x > trk_ff.start_x) ? trk_ff.last_x - trk_ff.start_x
                                                : trk_ff.start_x - trk_ff.last_x;
   assign dy = (trk_ff.last_y > trk_ff.start_y) ? trk_ff.last_y - trk_ff.start_y
                                                : trk_ff.start_y - trk_ff.last_y;
   assign held      = s1_item_ff.now_ms - trk_ff.press_time;
   assign since_tap = s1_item_ff.now_ms - trk_ff.last_accept_time;

   assign tap_ok = cfg.mapping_verified
                && (dx < cfg.max_move)
                && (dy < cfg.max_move)
                && (held >= TIME_W'(cfg.min_hold_ms))
                && (held < TIME_W'(cfg.max_hold_ms))
                && (since_tap > TIME_W'(cfg.refractory_ms));

   always_comb begin
      trk_in      = trk_ff;
      rsp_item_in = '0;
      if (s1_item_ff.read_ok) begin
         rsp_item_in.ack_status = s1_item_ff.status[READY_BIT];
         rsp_item_in.pos_x      = px;
         rsp_item_in.pos_y      = py;
         if (pressed && !trk_ff.touch_down) begin
            trk_in.touch_down = 1'b1;
            trk_in.start_x    = px;
            trk_in.start_y    = py;
            trk_in.last_x     = px;
            trk_in.last_y     = py;
            trk_in.press_time = s1_item_ff.now_ms;
         end else if (pressed) begin
            trk_in.last_x = px;
            trk_in.last_y = py;
         end else if (trk_ff.touch_down) begin
            // release: report at the start point
            trk_in.touch_down = 1'b0;
            rsp_item_in.pos_x = trk_ff.start_x;
            rsp_item_in.pos_y = trk_ff.start_y;
            if (tap_ok) begin
               trk_in.last_accept_time = s1_item_ff.now_ms;
               rsp_item_in.tap         = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         trk_ff       <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            trk_ff <= trk_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_item_ff <= req_item_type'({req_tuser, req_tdata});
      end
      if (advance) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

`ifndef ASSERT_OFF
   // a tap always ends a press
   a_tap_ends_press: assert property (@(posedge clock) disable iff (reset)
      advance && rsp_item_in.tap |=> !trk_ff.touch_down)
      else $error("tap issued without ending the press");

   // a failed read leaves the tracking state alone
   a_fail_keeps_state: assert property (@(posedge clock) disable iff (reset)
      advance && !s1_item_ff.read_ok |=> $stable(trk_ff))
      else $error("tracking state changed on a failed read");

   // a press starts only when a transaction moves into the result register
   a_press_on_advance: assert property (@(posedge clock) disable iff (reset)
      $rose(trk_ff.touch_down) |-> $past(advance))
      else $error("press started without a transaction");

   // back pressure only when both registers are full and the output stalls
   a_ready_low_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> s1_valid_ff && rsp_valid_ff && !rsp_tready)
      else $error("input stalled with room in the pipeline");
`endif

endmodule

`default_nettype wire

// ----- rtl/ttr_csr.sv -----
// ----------------------------------------------------------------------------
// ttr_csr
// APB register file holding the tap acceptance thresholds.
// ----------------------------------------------------------------------------
`default_nettype none

module ttr_csr (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_psel,
   input  wire logic                           csr_penable,
   input  wire logic                           csr_pwrite,
   input  wire logic [ttr_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [ttr_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic      [ttr_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                                csr_pready,
   output ttr_pkg::cfg_type                    cfg
);
   import ttr_pkg::*;

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       wr_en;
   logic [2:0] reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_idx    = csr_paddr[CSR_ADDR_W-1:2];
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_MAPPING_VERIFIED: cfg_in.mapping_verified = csr_pwdata[0];
            REG_MAX_MOVE:         cfg_in.max_move         = csr_pwdata[COORD_W-1:0];
            REG_MIN_HOLD_MS:      cfg_in.min_hold_ms      = csr_pwdata[HOLD_W-1:0];
            REG_MAX_HOLD_MS:      cfg_in.max_hold_ms      = csr_pwdata[HOLD_W-1:0];
            REG_REFRACTORY_MS:    cfg_in.refractory_ms    = csr_pwdata[HOLD_W-1:0];
            default:              cfg_in                  = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_MAPPING_VERIFIED: csr_prdata = CSR_DATA_W'(cfg_ff.mapping_verified);
         REG_MAX_MOVE:         csr_prdata = CSR_DATA_W'(cfg_ff.max_move);
         REG_MIN_HOLD_MS:      csr_prdata = CSR_DATA_W'(cfg_ff.min_hold_ms);
         REG_MAX_HOLD_MS:      csr_prdata = CSR_DATA_W'(cfg_ff.max_hold_ms);
         REG_REFRACTORY_MS:    csr_prdata = CSR_DATA_W'(cfg_ff.refractory_ms);
         default:              csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mapping_verified <= 1'b0;
         cfg_ff.max_move         <= MAX_MOVE_RST;
         cfg_ff.min_hold_ms      <= MIN_HOLD_MS_RST;
         cfg_ff.max_hold_ms      <= MAX_HOLD_MS_RST;
         cfg_ff.refractory_ms    <= REFRACTORY_MS_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire
